>>> src/unicycle_odometry_integrator_macros.svh
// Assertion macros for the unicycle odometry integrator.
// Define ASSERT_OFF to compile the checks out.
`ifndef UNICYCLE_ODOMETRY_INTEGRATOR_MACROS_SVH
`define UNICYCLE_ODOMETRY_INTEGRATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> src/uoi_pkg.sv
// Types and constants for the unicycle odometry integrator.
// No dependencies.
package uoi_pkg;
  localparam int AngW = 28;
  localparam int CrdW = 28;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [AngW-1:0] AngPi = 28'sd52707179;
  localparam logic signed [AngW-1:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [CrdW-1:0] CordicGain = 28'sd10188014;
  localparam int TableLen = 24;

  localparam logic [7:0] RegTimeStep = 8'd0;
  localparam logic [7:0] RegFilterGain = 8'd1;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0: atan_entry = 28'sd13176795;
      5'd1: atan_entry = 28'sd7778716;
      5'd2: atan_entry = 28'sd4110060;
      5'd3: atan_entry = 28'sd2086331;
      5'd4: atan_entry = 28'sd1047214;
      5'd5: atan_entry = 28'sd524117;
      5'd6: atan_entry = 28'sd262123;
      5'd7: atan_entry = 28'sd131069;
      default: atan_entry = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
    endcase
  endfunction

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_CORD  = 7'b0000100,
    S_POS   = 7'b0001000,
    S_CORD2 = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic load;
    logic head;
    logic cord_init;
    logic cord_half;
    logic cord_step;
    logic pos_mul;
    logic pos_add;
    logic quat;
    logic filt;
  } cmd_t;
endpackage

>>> src/uoi_ctrl.sv
// Sequencer for the integrator: steps heading, CORDIC passes, position, output.
// Depends on uoi_pkg.
module uoi_ctrl import uoi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_beat,
  input  logic out_busy,
  output logic busy,
  output logic out_load,
  output logic [4:0] iter,
  output cmd_t cmd
);
  localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
  state_t state, state_next;
  logic [4:0] iter_next;
  logic [1:0] sub, sub_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter <= '0;
      sub <= '0;
    end else begin
      state <= state_next;
      iter <= iter_next;
      sub <= sub_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next = iter;
    sub_next = sub;
    cmd = '0;
    out_load = 1'b0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_beat;
        if (in_beat) state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        state_next = S_CORD;
        sub_next = '0;
      end
      S_CORD: begin
        if (sub == 2'd0) begin
          cmd.cord_init = 1'b1;
          sub_next = 2'd1;
          iter_next = '0;
        end else begin
          cmd.cord_step = 1'b1;
          iter_next = iter + 5'd1;
          if (iter == 5'(Steps - 1)) begin
            state_next = S_POS;
            sub_next = '0;
          end
        end
      end
      S_POS: begin
        if (sub == 2'd0) begin
          cmd.pos_mul = 1'b1;
          sub_next = 2'd1;
        end else begin
          cmd.pos_add = 1'b1;
          cmd.filt = 1'b1;
          sub_next = '0;
          state_next = S_CORD2;
        end
      end
      S_CORD2: begin
        if (sub == 2'd0) begin
          cmd.cord_init = 1'b1;
          cmd.cord_half = 1'b1;
          sub_next = 2'd1;
          iter_next = '0;
        end else begin
          cmd.cord_step = 1'b1;
          iter_next = iter + 5'd1;
          if (iter == 5'(Steps - 1)) state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.quat = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> src/uoi_dp.sv
// Datapath: heading, shared CORDIC, position multiply/accumulate, filters.
// Depends on uoi_pkg.
module uoi_dp import uoi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic [4:0] iter,
  input  logic [15:0] time_step,
  input  logic [15:0] filter_gain,
  input  logic signed [15:0] linear_velocity,
  input  logic signed [15:0] angular_velocity,
  output logic signed [31:0] px,
  output logic signed [31:0] py,
  output logic signed [15:0] hd,
  output logic signed [15:0] fl,
  output logic signed [15:0] fa,
  output logic signed [15:0] qz,
  output logic signed [15:0] qw
);
  logic signed [15:0] v, w;
  logic signed [CrdW-1:0] cx, cy, cx_o, cy_o;
  logic signed [AngW-1:0] cz, ang, ang_f;
  logic neg, fold;
  logic signed [32:0] dv;
  logic signed [60:0] mx, my;
  logic signed [33:0] sx, sy;
  logic signed [17:0] hsum, h1, h2;
  logic signed [16:0] dtw;

  assign dtw = 17'((34'(signed'({1'b0, time_step})) * 34'(w) + 34'sd16384) >>> 15);
  assign hsum = 18'(hd) + 18'(dtw);
  always_comb begin
    h1 = hsum;
    if (h1 > 18'(PiQ13)) h1 = h1 - 18'sd51472;
    else if (h1 < -18'(PiQ13)) h1 = h1 + 18'sd51472;
    h2 = h1;
    if (h2 > 18'(PiQ13)) h2 = h2 - 18'sd51472;
    else if (h2 < -18'(PiQ13)) h2 = h2 + 18'sd51472;
  end

  assign ang = cmd.cord_half ? AngW'(hd) <<< 10 : AngW'(hd) <<< 11;
  always_comb begin
    fold = 1'b0;
    ang_f = ang;
    if (ang > AngHalfPi) begin
      ang_f = ang - AngPi;
      fold = 1'b1;
    end else if (ang < -AngHalfPi) begin
      ang_f = ang + AngPi;
      fold = 1'b1;
    end
  end
  assign cx_o = neg ? -cx : cx;
  assign cy_o = neg ? -cy : cy;

  function automatic logic signed [15:0] filt(input logic [15:0] g,
      input logic signed [15:0] s, input logic signed [15:0] x);
    logic signed [16:0] d;
    logic signed [34:0] p;
    logic signed [18:0] r;
    begin
      d = 17'(x) - 17'(s);
      p = 35'(signed'({1'b0, g})) * 35'(d) + 35'sd32768;
      r = 19'(p >>> 16) + 19'(s);
      if (r > 19'sd32767) filt = 16'sh7fff;
      else if (r < -19'sd32768) filt = 16'sh8000;
      else filt = 16'(r);
    end
  endfunction

  function automatic logic signed [15:0] qrnd(input logic signed [CrdW-1:0] a);
    logic signed [CrdW-1:0] r;
    begin
      r = (a + CrdW'(512)) >>> 10;
      if (r > CrdW'(16384)) qrnd = 16'sd16384;
      else if (r < -CrdW'(16384)) qrnd = -16'sd16384;
      else qrnd = 16'(r);
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [33:0] a);
    if (a > 34'sh7fffffff) sat = 32'sh7fffffff;
    else if (a < -34'sh80000000) sat = 32'sh80000000;
    else sat = 32'(a);
  endfunction

  assign sx = 34'(px) + 34'((mx + 61'sh800000000) >>> 36);
  assign sy = 34'(py) + 34'((my + 61'sh800000000) >>> 36);

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      hd <= '0;
      fl <= '0;
      fa <= '0;
      qz <= '0;
      qw <= '0;
    end else begin
      if (cmd.head) hd <= 16'(h2);
      if (cmd.pos_add) begin
        px <= sat(sx);
        py <= sat(sy);
      end
      if (cmd.filt) begin
        fl <= filt(filter_gain, fl, v);
        fa <= filt(filter_gain, fa, w);
      end
      if (cmd.quat) begin
        qz <= qrnd(cy_o);
        qw <= qrnd(cx_o);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= linear_velocity;
      w <= angular_velocity;
    end
    if (cmd.head) dv <= 33'(signed'({1'b0, time_step})) * 33'(v);
    if (cmd.pos_mul) begin
      mx <= 61'(dv) * 61'(cx_o);
      my <= 61'(dv) * 61'(cy_o);
    end
    if (cmd.cord_init) begin
      cx <= CordicGain;
      cy <= '0;
      cz <= ang_f;
      neg <= fold;
    end else if (cmd.cord_step) begin
      if (cz >= 0) begin
        cx <= cx - (cy >>> iter);
        cy <= cy + (cx >>> iter);
        cz <= cz - atan_entry(iter);
      end else begin
        cx <= cx + (cy >>> iter);
        cy <= cy - (cx >>> iter);
        cz <= cz + atan_entry(iter);
      end
    end
  end
endmodule

>>> src/unicycle_odometry_integrator.sv
// Unicycle odometry integrator: heading, position, filtered rates and the
// heading quaternion from velocity commands. One item at a time: the heading goes
// through two passes of the shared CORDIC iteration unit, and the next beat is
// taken only after the result has been loaded into the output register.
// A result stalled in the output register holds the sequencer until it leaves.
// Register writes with an index beyond 1 are ignored.
// Depends on uoi_pkg, uoi_ctrl, uoi_dp.
`include "unicycle_odometry_integrator_macros.svh"
module unicycle_odometry_integrator import uoi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] linear_velocity,
  input  logic signed [15:0] angular_velocity,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic signed [15:0] filtered_linear,
  output logic signed [15:0] filtered_angular,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w
);
  logic [15:0] time_step, filter_gain;
  logic busy, out_load, in_beat;
  logic [4:0] iter;
  cmd_t cmd;
  logic signed [31:0] px, py;
  logic signed [15:0] hd, fl, fa, qz, qw;

  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign in_beat = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 16'd3277;
      filter_gain <= 16'd6554;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegTimeStep: time_step <= cfg_data;
        RegFilterGain: filter_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  uoi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_beat, .out_busy(out_valid && out_stall),
    .busy, .out_load, .iter, .cmd
  );

  uoi_dp u_dp (
    .clk, .rst, .cmd, .iter, .time_step, .filter_gain,
    .linear_velocity, .angular_velocity,
    .px, .py, .hd, .fl, .fa, .qz, .qw
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x <= px;
      pos_y <= py;
      heading <= hd;
      filtered_linear <= fl;
      filtered_angular <= fa;
      quat_z <= qz;
      quat_w <= qw;
    end
  end

  `ASSERT_NEXT(a_load_valid, clk, rst, out_load, out_valid)
  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, busy, in_stall)
  `ASSERT_IMPLIES(a_head_range, clk, rst, out_valid, heading <= PiQ13 && heading >= -PiQ13)
endmodule
